@@ sv/rrds_pkg.sv @@
// ----------------------------------------------------------------------------
// rrds_pkg: shared types and constants of the role dwell scheduler
// Payload structs, event, phase and action codes, and the command and
// response groups of the serial divider and serial multiplier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rrds_pkg;

   // Field widths
   localparam int TIME_BITS    = 32;
   localparam int NOW_BITS     = 32;
   localparam int RAND_BITS    = 32;
   localparam int MIN_BITS     = 16;
   localparam int PCT_BITS     = 7;
   localparam int GRACE_BITS   = 32;
   localparam int DWELL_BITS   = 17;
   localparam int CSR_BITS     = 32;
   localparam int PROD_BITS    = MIN_BITS + PCT_BITS;
   localparam int DVS_BITS     = MIN_BITS + 1;
   localparam int DIV_STEPS    = RAND_BITS;
   localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);
   localparam int MUL_STEPS    = PCT_BITS;
   localparam int MUL_CNT_BITS = $clog2(MUL_STEPS);

   // Register reset values and arithmetic constants
   localparam logic [MIN_BITS-1:0]   DWELL_MIN_RESET = 16'd1000;
   localparam logic [MIN_BITS-1:0]   DWELL_MAX_RESET = 16'd3000;
   localparam logic [PCT_BITS-1:0]   JITTER_RESET    = 7'd10;
   localparam logic [GRACE_BITS-1:0] GRACE_RESET     = 32'd5000;
   localparam logic [PCT_BITS-1:0]   JITTER_CAP      = 7'd100;
   localparam logic [DVS_BITS-1:0]   PCT_DIVISOR     = 17'd100;

   typedef logic [TIME_BITS-1:0] tstamp_type;

   typedef enum logic [1:0] {
      REQ_TICK       = 2'd0,
      REQ_START      = 2'd1,
      REQ_CONNECT    = 2'd2,
      REQ_DISCONNECT = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      PH_GRACE = 2'd0,
      PH_ADV   = 2'd1,
      PH_SCAN  = 2'd2,
      PH_CONN  = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      ACT_NONE = 2'd0,
      ACT_ADV  = 2'd1,
      ACT_SCAN = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      CSR_DWELL_MIN = 2'd0,
      CSR_DWELL_MAX = 2'd1,
      CSR_JITTER    = 2'd2,
      CSR_GRACE     = 2'd3
   } csr_idx_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_BASE,
      ST_MUL,
      ST_RANGE,
      ST_JIT,
      ST_DONE
   } sched_state_type;

   typedef struct packed {
      req_kind_type          req_type;
      logic [NOW_BITS-1:0]   now_ms;
      logic [RAND_BITS-1:0]  rand_role;
      logic [RAND_BITS-1:0]  rand_base;
      logic [RAND_BITS-1:0]  rand_jitter;
   } req_payload_type;

   typedef struct packed {
      action_type            action;
      phase_type             phase_now;
      logic [DWELL_BITS-1:0] dwell_drawn_ms;
   } rsp_payload_type;

   typedef struct packed {
      logic                 start;
      logic [RAND_BITS-1:0] dividend;
      logic [DVS_BITS-1:0]  divisor;
   } div_cmd_type;

   typedef struct packed {
      logic                 done;
      logic [RAND_BITS-1:0] quotient;
      logic [DVS_BITS-1:0]  remainder;
   } div_rsp_type;

   typedef struct packed {
      logic                start;
      logic [MIN_BITS-1:0] mcand;
      logic [PCT_BITS-1:0] mplr;
   } mul_cmd_type;

   typedef struct packed {
      logic                 done;
      logic [PROD_BITS-1:0] product;
   } mul_rsp_type;

endpackage

@@ sv/rrds_div.sv @@
// ----------------------------------------------------------------------------
// rrds_div: bit-serial restoring divider
// Retires one quotient bit per cycle; the dividend shifts out at the top
// while quotient bits shift in at the bottom of the same register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rrds_div (
   input  logic                 clock,
   input  logic                 reset,
   input  rrds_pkg::div_cmd_type div_cmd,
   output rrds_pkg::div_rsp_type div_rsp
);
   import rrds_pkg::*;

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [DIV_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [RAND_BITS-1:0]    quo_ff, quo_in;
   logic [DVS_BITS-1:0]     rem_ff, rem_in;
   logic [DVS_BITS-1:0]     dvs_ff, dvs_in;
   logic [DVS_BITS:0]       trial;
   logic [DVS_BITS+1:0]     diff;

   // Trial subtract of the divisor from the shifted partial remainder
   assign trial = {rem_ff, quo_ff[RAND_BITS-1]};
   assign diff  = {1'b0, trial} - {2'b00, dvs_ff};

   // Load a new transaction or advance one quotient bit
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      priority if (div_cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_BITS'(DIV_STEPS - 1);
         quo_in  = div_cmd.dividend;
         rem_in  = '0;
         dvs_in  = div_cmd.divisor;
      end else if (busy_ff) begin
         if (!diff[DVS_BITS+1]) begin
            rem_in = diff[DVS_BITS-1:0];
            quo_in = {quo_ff[RAND_BITS-2:0], 1'b1};
         end else begin
            rem_in = trial[DVS_BITS-1:0];
            quo_in = {quo_ff[RAND_BITS-2:0], 1'b0};
         end
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end else begin
         // Idle: hold the operands
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

@@ sv/rrds_mul.sv @@
// ----------------------------------------------------------------------------
// rrds_mul: bit-serial shift-add multiplier
// Scales the base dwell by the jitter percent, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rrds_mul (
   input  logic                 clock,
   input  logic                 reset,
   input  rrds_pkg::mul_cmd_type mul_cmd,
   output rrds_pkg::mul_rsp_type mul_rsp
);
   import rrds_pkg::*;

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [MUL_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [PROD_BITS-1:0]    mcand_ff, mcand_in;
   logic [PCT_BITS-1:0]     mplr_ff, mplr_in;
   logic [PROD_BITS-1:0]    acc_ff, acc_in;

   // Load a new transaction or add one shifted partial product
   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      mcand_in = mcand_ff;
      mplr_in  = mplr_ff;
      acc_in   = acc_ff;
      priority if (mul_cmd.start) begin
         busy_in  = 1'b1;
         cnt_in   = MUL_CNT_BITS'(MUL_STEPS - 1);
         mcand_in = PROD_BITS'(mul_cmd.mcand);
         mplr_in  = mul_cmd.mplr;
         acc_in   = '0;
      end else if (busy_ff) begin
         if (mplr_ff[0]) begin
            acc_in = acc_ff + mcand_ff;
         end
         mcand_in = {mcand_ff[PROD_BITS-2:0], 1'b0};
         mplr_in  = {1'b0, mplr_ff[PCT_BITS-1:1]};
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end else begin
         // Idle: hold the operands
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      mcand_ff <= mcand_in;
      mplr_ff  <= mplr_in;
      acc_ff   <= acc_in;
   end

   assign mul_rsp.done    = done_ff;
   assign mul_rsp.product = acc_ff;

endmodule

@@ sv/randomized_role_dwell_scheduler_unit.sv @@
// ----------------------------------------------------------------------------
// randomized_role_dwell_scheduler_unit: grace/advertise/scan/connect scheduler
// Flow: a request is taken only in IDLE, so one transaction finishes before
// the next is accepted; a role flip runs a divide, a multiply and two more
// divides in turn, and DONE waits while an earlier result is still untaken.
// Reset: synchronous; grace phase, registers to defaults, deadlines rearmed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module randomized_role_dwell_scheduler_unit (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  rrds_pkg::req_payload_type req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rrds_pkg::rsp_payload_type rsp_data,
   input  logic                      csr_we,
   input  rrds_pkg::csr_idx_type     csr_addr,
   input  logic [rrds_pkg::CSR_BITS-1:0] csr_wdata
);
   import rrds_pkg::*;

   // Wrap-safe deadline check: reached when now - deadline is not negative
   function automatic logic time_reached(tstamp_type now_t, tstamp_type dl);
      tstamp_type diff;
      diff = now_t - dl;
      return ~diff[TIME_BITS-1];
   endfunction

   sched_state_type        state_ff, state_in;
   req_payload_type        req_ff;
   logic                   req_accept;

   logic [MIN_BITS-1:0]    dmin_ff;
   logic [MIN_BITS-1:0]    dmax_ff;
   logic [PCT_BITS-1:0]    jit_ff;
   logic [GRACE_BITS-1:0]  grace_ff;

   phase_type              phase_ff, phase_in;
   tstamp_type             dwell_dl_ff, dwell_dl_in;
   tstamp_type             grace_dl_ff, grace_dl_in;

   logic                   fire_ff, fire_in;
   logic [MIN_BITS-1:0]    base_ff, base_in;
   logic [MIN_BITS-1:0]    range_ff, range_in;
   logic [DWELL_BITS-1:0]  dwell_ff, dwell_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_payload_type        rsp_ff, rsp_in;

   div_cmd_type            div_cmd;
   div_rsp_type            div_rsp;
   mul_cmd_type            mul_cmd;
   mul_rsp_type            mul_rsp;

   tstamp_type             now_t;
   logic                   fire_now;
   logic                   commit;
   logic [DVS_BITS-1:0]    span_p1;
   logic [MIN_BITS-1:0]    base_sum;
   logic [PCT_BITS-1:0]    pct_sat;
   logic [DWELL_BITS:0]    jit_sum;
   logic [DWELL_BITS-1:0]  dwell_floor;
   logic [DWELL_BITS-1:0]  dwell_calc;
   action_type             act;
   phase_type              new_phase;
   logic [DWELL_BITS-1:0]  dwell_out;

   assign req_accept = req_valid && req_ready;
   assign now_t      = tstamp_type'(req_ff.now_ms);

   // Decide whether this tick flips the role
   always_comb begin
      fire_now = 1'b0;
      if (req_ff.req_type == REQ_TICK) begin
         if (phase_ff == PH_GRACE) begin
            fire_now = time_reached(now_t, grace_dl_ff);
         end else if (phase_ff == PH_ADV || phase_ff == PH_SCAN) begin
            fire_now = time_reached(now_t, dwell_dl_ff);
         end
      end
   end

   // Dwell draw arithmetic around the serial units
   assign span_p1     = (dmax_ff >= dmin_ff) ?
                        (DVS_BITS'(dmax_ff) - DVS_BITS'(dmin_ff) + 1'b1) :
                        DVS_BITS'(1);
   assign base_sum    = dmin_ff + div_rsp.remainder[MIN_BITS-1:0];
   assign pct_sat     = (jit_ff > JITTER_CAP) ? JITTER_CAP : jit_ff;
   assign jit_sum     = (DWELL_BITS+1)'(base_ff) + (DWELL_BITS+1)'(div_rsp.remainder)
                        - (DWELL_BITS+1)'(range_ff);
   assign dwell_floor = DWELL_BITS'(dmin_ff >> 1);
   assign dwell_calc  = (jit_sum[DWELL_BITS-1:0] < dwell_floor) ?
                        dwell_floor : jit_sum[DWELL_BITS-1:0];

   // Sequencer: next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_accept) state_in = ST_EVAL;
         ST_EVAL:  state_in = fire_now ? ST_BASE : ST_DONE;
         ST_BASE:  if (div_rsp.done) state_in = ST_MUL;
         ST_MUL:   if (mul_rsp.done) state_in = ST_RANGE;
         ST_RANGE: if (div_rsp.done) state_in = ST_JIT;
         ST_JIT:   if (div_rsp.done) state_in = ST_DONE;
         ST_DONE:  if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Sequencer: unit commands and working register loads
   always_comb begin
      req_ready = 1'b0;
      commit    = 1'b0;
      div_cmd   = '0;
      mul_cmd   = '0;
      fire_in   = fire_ff;
      base_in   = base_ff;
      range_in  = range_ff;
      dwell_in  = dwell_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
         end
         ST_EVAL: begin
            fire_in = fire_now;
            if (fire_now) begin
               div_cmd.start    = 1'b1;
               div_cmd.dividend = req_ff.rand_base;
               div_cmd.divisor  = span_p1;
            end
         end
         ST_BASE: begin
            if (div_rsp.done) begin
               base_in       = base_sum;
               mul_cmd.start = 1'b1;
               mul_cmd.mcand = base_sum;
               mul_cmd.mplr  = pct_sat;
            end
         end
         ST_MUL: begin
            if (mul_rsp.done) begin
               div_cmd.start    = 1'b1;
               div_cmd.dividend = RAND_BITS'(mul_rsp.product);
               div_cmd.divisor  = PCT_DIVISOR;
            end
         end
         ST_RANGE: begin
            if (div_rsp.done) begin
               range_in         = div_rsp.quotient[MIN_BITS-1:0];
               div_cmd.start    = 1'b1;
               div_cmd.dividend = req_ff.rand_jitter;
               div_cmd.divisor  = {div_rsp.quotient[MIN_BITS-1:0], 1'b1};
            end
         end
         ST_JIT: begin
            if (div_rsp.done) begin
               dwell_in = dwell_calc;
            end
         end
         ST_DONE: begin
            commit = !rsp_valid_ff || rsp_ready;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // Apply the event to phase and deadlines and form the result
   always_comb begin
      act         = ACT_NONE;
      new_phase   = phase_ff;
      dwell_out   = '0;
      dwell_dl_in = dwell_dl_ff;
      grace_dl_in = grace_dl_ff;
      unique case (req_ff.req_type)
         REQ_TICK: begin
            if (fire_ff) begin
               dwell_out   = dwell_ff;
               dwell_dl_in = now_t + tstamp_type'(dwell_ff);
               if (req_ff.rand_role[0]) begin
                  new_phase = PH_ADV;
                  act       = ACT_ADV;
               end else begin
                  new_phase = PH_SCAN;
                  act       = ACT_SCAN;
               end
            end
         end
         REQ_START: begin
            new_phase   = PH_GRACE;
            grace_dl_in = now_t + tstamp_type'(grace_ff);
            dwell_dl_in = '0;
         end
         REQ_CONNECT: begin
            new_phase = PH_CONN;
         end
         REQ_DISCONNECT: begin
            new_phase   = PH_ADV;
            dwell_dl_in = now_t;
         end
         default: begin
            new_phase = phase_ff;
         end
      endcase
      phase_in = new_phase;
      rsp_in   = '{action: act, phase_now: new_phase, dwell_drawn_ms: dwell_out};
   end

   // Hold the result until the transaction is taken
   assign rsp_valid_in = commit || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         fire_ff      <= 1'b0;
         phase_ff     <= PH_GRACE;
         dwell_dl_ff  <= '0;
         grace_dl_ff  <= tstamp_type'(GRACE_RESET);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         fire_ff      <= fire_in;
         if (commit) begin
            phase_ff    <= phase_in;
            dwell_dl_ff <= dwell_dl_in;
            grace_dl_ff <= grace_dl_in;
         end
      end
   end

   // Capture the request and working values
   always_ff @(posedge clock) begin
      if (req_accept) begin
         req_ff <= req_data;
      end
      if (commit) begin
         rsp_ff <= rsp_in;
      end
      base_ff  <= base_in;
      range_ff <= range_in;
      dwell_ff <= dwell_in;
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         dmin_ff  <= DWELL_MIN_RESET;
         dmax_ff  <= DWELL_MAX_RESET;
         jit_ff   <= JITTER_RESET;
         grace_ff <= GRACE_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_DWELL_MIN: dmin_ff  <= csr_wdata[MIN_BITS-1:0];
            CSR_DWELL_MAX: dmax_ff  <= csr_wdata[MIN_BITS-1:0];
            CSR_JITTER:    jit_ff   <= csr_wdata[PCT_BITS-1:0];
            CSR_GRACE:     grace_ff <= csr_wdata[GRACE_BITS-1:0];
            default:       dmin_ff  <= dmin_ff;
         endcase
      end
   end

   rrds_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_cmd (div_cmd),
      .div_rsp (div_rsp)
   );

   rrds_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_cmd (mul_cmd),
      .mul_rsp (mul_rsp)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef NO_ASSERTIONS
   a_none_no_dwell: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.action == ACT_NONE) |-> (rsp_data.dwell_drawn_ms == '0))
      else $error("result without a flip carries a dwell");

   a_flip_phase: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.action != ACT_NONE) |->
      ((rsp_data.action == ACT_ADV && rsp_data.phase_now == PH_ADV) ||
       (rsp_data.action == ACT_SCAN && rsp_data.phase_now == PH_SCAN)))
      else $error("flip action and phase disagree");

   a_div_owner: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_BASE || state_ff == ST_RANGE || state_ff == ST_JIT))
      else $error("divider finished outside a divide step");

   a_mul_owner: assert property (@(posedge clock) disable iff (reset)
      mul_rsp.done |-> (state_ff == ST_MUL))
      else $error("multiplier finished outside the scale step");
`endif

endmodule
